// ----- design/uvtp_pkg.sv -----
`default_nettype none

package uvtp_pkg;

    localparam int POS_W      = 6;
    localparam int CNT_W      = 6;
    localparam int DIGITS_N   = 32;
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = 4;
    localparam int REM_W      = 14;
    localparam int V_W        = REM_W + CHUNK_W;
    localparam int PROD_W     = 61;
    localparam int TIME_W     = 51;
    localparam int CSEQ_W     = 14;
    localparam int NODE_W     = 48;
    localparam int REST_W     = (NUM_CHUNKS - 1) * CHUNK_W;
    localparam int OUT_W      = 248;

    localparam logic [POS_W-1:0] CANON_LEN = 6'd36;
    localparam logic [POS_W-1:0] POS_SAT   = 6'd37;
    localparam logic [CNT_W-1:0] DIGITS    = 6'd32;

    localparam logic [POS_W-1:0] HYPH_A = 6'd8;
    localparam logic [POS_W-1:0] HYPH_B = 6'd13;
    localparam logic [POS_W-1:0] HYPH_C = 6'd18;
    localparam logic [POS_W-1:0] HYPH_D = 6'd23;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [3:0] VERSION_1 = 4'h1;

    // Offset between the UUID epoch (1582-10-15) and the Unix epoch, in 100 ns ticks.
    localparam logic [63:0] EPOCH_OFFSET = 64'd122192928000000000;

    // Division by 10000 is done by multiplying with ceil(2^44 / 10000) and shifting.
    localparam logic [REM_W-1:0] TICKS_PER_MS = 14'd10000;
    localparam logic [30:0]      RECIP_MULT   = 31'd1759218605;
    localparam int               RECIP_SHIFT  = 44;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEN    = 3'd1,
        ST_BAD_HYPHEN = 3'd2,
        ST_BAD_HEX    = 3'd3,
        ST_NOT_V1     = 3'd4
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        t_status     status;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_capt;

    typedef struct packed {
        t_status            status;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic [REST_W-1:0]  rest;
        logic [V_W-1:0]     v;
        logic [PROD_W-1:0]  prod;
        logic [TIME_W-1:0]  quot;
    } t_pipe;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            h.val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.val = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_hyphen_slot(input logic [POS_W-1:0] pos);
        return pos inside {HYPH_A, HYPH_B, HYPH_C, HYPH_D};
    endfunction

endpackage

`default_nettype wire

// ----- design/uvtp_parser.sv -----
`default_nettype none

module uvtp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_data,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output logic            o_ready,
    output logic            o_valid,
    output uvtp_pkg::t_capt o_data,
    input  logic            i_ready
);
    import uvtp_pkg::*;

    logic             r_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_hyph_err, n_hyph_err;
    logic             r_hex_err, n_hex_err;
    logic [3:0]       r_digits [DIGITS_N];
    logic [3:0]       n_digits [DIGITS_N];
    logic             r_valid;
    t_capt            r_out, n_out;
    logic             accept;
    logic             store;
    t_hex             hx;
    logic [127:0]     value;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        hx         = hex_decode(i_char);
        n_hyph_err = r_hyph_err;
        n_hex_err  = r_hex_err;
        store      = 1'b0;
        if (!r_mode) begin
            if (r_pos < CANON_LEN) begin
                if (is_hyphen_slot(r_pos)) begin
                    if (i_char != CH_HYPHEN) n_hyph_err = 1'b1;
                end else begin
                    // A bad character still takes its digit slot, stored as zero.
                    if (!hx.ok) n_hex_err = 1'b1;
                    store = (r_cnt < DIGITS);
                end
            end
        end else if (r_cnt < DIGITS && i_char != CH_HYPHEN) begin
            if (!hx.ok) begin
                n_hex_err = 1'b1;
            end else if (!r_hex_err) begin
                store = 1'b1;
            end
        end
        n_cnt = store ? r_cnt + 1'b1 : r_cnt;
        n_pos = (r_pos < POS_SAT) ? r_pos + 1'b1 : r_pos;

        for (int i = 0; i < DIGITS_N; i++) begin
            n_digits[i] = (store && r_cnt[4:0] == 5'(i)) ? hx.val : r_digits[i];
        end
        for (int i = 0; i < DIGITS_N; i++) begin
            value[127 - 4*i -: 4] = n_digits[i];
        end

        n_out.hi = value[127:64];
        n_out.lo = value[63:0];
        if (!r_mode) begin
            if (n_pos != CANON_LEN)  n_out.status = ST_BAD_LEN;
            else if (n_hyph_err)     n_out.status = ST_BAD_HYPHEN;
            else if (n_hex_err)      n_out.status = ST_BAD_HEX;
            else                     n_out.status = ST_OK;
        end else begin
            if (n_hex_err)           n_out.status = ST_BAD_HEX;
            else if (n_cnt != DIGITS) n_out.status = ST_BAD_LEN;
            else                     n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_hyph_err <= 1'b0;
            r_hex_err  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (accept) begin
                if (i_last) begin
                    r_pos      <= '0;
                    r_cnt      <= '0;
                    r_hyph_err <= 1'b0;
                    r_hex_err  <= 1'b0;
                end else begin
                    r_pos      <= n_pos;
                    r_cnt      <= n_cnt;
                    r_hyph_err <= n_hyph_err;
                    r_hex_err  <= n_hex_err;
                end
            end
            if (o_ready) r_valid <= accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_digits <= n_digits;
        if (accept && i_last) r_out <= n_out;
    end

endmodule

`default_nettype wire

// ----- design/uvtp_prep.sv -----
`default_nettype none

module uvtp_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uvtp_pkg::t_capt i_data,
    output logic            o_ready,
    output logic            o_valid,
    output uvtp_pkg::t_pipe o_data,
    input  logic            i_ready
);
    import uvtp_pkg::*;

    logic        r_valid;
    t_pipe       r_data, n_data;
    logic [59:0] ts;
    logic [63:0] diff;
    logic        ok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        // Version-1 timestamp: the 12 high bits beside the version, then the
        // middle 16-bit word, then the low 32-bit word.
        ts   = {i_data.hi[11:0], i_data.hi[31:16], i_data.hi[63:32]};
        diff = {4'h0, ts} - EPOCH_OFFSET;
        n_data.status = i_data.status;
        if (i_data.status == ST_OK && i_data.hi[15:12] != VERSION_1) begin
            n_data.status = ST_NOT_V1;
        end
        ok          = (n_data.status == ST_OK);
        n_data.hi   = ok ? i_data.hi : '0;
        n_data.lo   = ok ? i_data.lo : '0;
        n_data.v    = V_W'(diff[63 -: CHUNK_W]);
        n_data.rest = diff[REST_W-1:0];
        n_data.prod = '0;
        n_data.quot = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- design/uvtp_div_mul.sv -----
`default_nettype none

module uvtp_div_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uvtp_pkg::t_pipe i_data,
    output logic            o_ready,
    output logic            o_valid,
    output uvtp_pkg::t_pipe o_data,
    input  logic            i_ready
);
    import uvtp_pkg::*;

    logic  r_valid;
    t_pipe r_data, n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data      = i_data;
        n_data.prod = PROD_W'(i_data.v) * PROD_W'(RECIP_MULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- design/uvtp_div_rem.sv -----
`default_nettype none

module uvtp_div_rem (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uvtp_pkg::t_pipe i_data,
    output logic            o_ready,
    output logic            o_valid,
    output uvtp_pkg::t_pipe o_data,
    input  logic            i_ready
);
    import uvtp_pkg::*;

    logic               r_valid;
    t_pipe              r_data, n_data;
    logic [CHUNK_W-1:0] q;
    logic [V_W-1:0]     qd;
    logic [REM_W-1:0]   rem;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        // The partial dividend stays below 10000 * 2^16, so the quotient digit fits 16 bits.
        q    = i_data.prod[RECIP_SHIFT +: CHUNK_W];
        qd   = V_W'(q) * V_W'(TICKS_PER_MS);
        rem  = REM_W'(i_data.v - qd);
        n_data      = i_data;
        n_data.v    = {rem, i_data.rest[REST_W-1 -: CHUNK_W]};
        n_data.rest = {i_data.rest[REST_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        n_data.quot = (i_data.status == ST_OK) ?
                      {i_data.quot[TIME_W-CHUNK_W-1:0], q} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- design/uuid_v1_text_parser.sv -----
`default_nettype none

// Parses a version-1 UUID text streamed one character per item, with tlast on
// the final character, and returns one result item per string: status, the
// 128-bit value, the Unix millisecond time, the clock sequence and the node.
// parse_mode 0 wants the canonical 36-character hyphenated form; 1 skips
// hyphens and takes the first 32 hex digits. One character is taken per clock
// cycle with no gaps while the output is not stalled; the result passes through
// the parse register, the version and epoch stage, and four two-stage steps that
// divide the tick count by 10000 one 16-bit chunk at a time. Every stage is
// elastic, so bubbles absorb output stalls before input is held off.
// Write parse_mode only while no string is in progress.
module uuid_v1_text_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [7:0] text_char
    input  logic [7:0]                  i_s_axis_tdata,
    input  logic                        i_s_axis_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [2:0] status, [66:3] uuid_high, [130:67] uuid_low, [181:131] time_ms,
    // [195:182] clock_sequence, [243:196] node_id, [247:244] zero
    output logic [uvtp_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    import uvtp_pkg::*;

    localparam int NODES = 2 * NUM_CHUNKS + 1;

    t_capt capt_d;
    logic  capt_v, capt_r;
    t_pipe pd [NODES];
    logic  pv [NODES];
    logic  pr [NODES];

    assign o_cfg_ready = 1'b1;

    uvtp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .o_valid     (capt_v),
        .o_data      (capt_d),
        .i_ready     (capt_r)
    );

    uvtp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (capt_v),
        .i_data  (capt_d),
        .o_ready (capt_r),
        .o_valid (pv[0]),
        .o_data  (pd[0]),
        .i_ready (pr[0])
    );

    for (genvar k = 0; k < NUM_CHUNKS; k++) begin : g_div
        uvtp_div_mul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (pv[2*k]),
            .i_data  (pd[2*k]),
            .o_ready (pr[2*k]),
            .o_valid (pv[2*k+1]),
            .o_data  (pd[2*k+1]),
            .i_ready (pr[2*k+1])
        );
        uvtp_div_rem u_rem (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (pv[2*k+1]),
            .i_data  (pd[2*k+1]),
            .o_ready (pr[2*k+1]),
            .o_valid (pv[2*k+2]),
            .o_data  (pd[2*k+2]),
            .i_ready (pr[2*k+2])
        );
    end

    assign pr[NODES-1]     = i_m_axis_tready;
    assign o_m_axis_tvalid = pv[NODES-1];
    assign o_m_axis_tdata  = {4'h0,
                              pd[NODES-1].lo[NODE_W-1:0],
                              pd[NODES-1].lo[NODE_W +: CSEQ_W],
                              pd[NODES-1].quot,
                              pd[NODES-1].lo,
                              pd[NODES-1].hi,
                              pd[NODES-1].status};

endmodule

`default_nettype wire

// ----- design/uvtp_checker.sv -----
`default_nettype none

module uvtp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [uvtp_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import uvtp_pkg::*;

    logic [2:0]  st;
    logic [63:0] lo;
    logic [3:0]  ver;

    assign st  = o_m_axis_tdata[2:0];
    assign lo  = o_m_axis_tdata[130:67];
    assign ver = o_m_axis_tdata[18:15];

    // A result held back by the sink stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> st <= 3'(ST_NOT_V1))
        else $error("status code out of range");

    // A good result always carries version 1 in byte 6.
    a_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && st == 3'(ST_OK) |-> ver == VERSION_1)
        else $error("accepted UUID is not version 1");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && st != 3'(ST_OK) |-> o_m_axis_tdata[OUT_W-1:3] == '0)
        else $error("error result carries nonzero fields");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[195:182] == lo[61:48] && o_m_axis_tdata[243:196] == lo[47:0])
        else $error("clock sequence or node disagrees with the low half");

endmodule

bind uuid_v1_text_parser uvtp_checker u_uvtp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/tb_uuid_v1_text_parser.sv -----
module tb_uuid_v1_text_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import uvtp_pkg::*;

    localparam logic [7:0]  DASH_CHAR    = 8'h2D;
    localparam logic [63:0] GREG_TO_UNIX = 64'd122192928000000000;
    localparam int          IDLE_LIMIT   = 2000;
    localparam string       V1_TEXT      = "c232ab00-9414-11ec-b3c8-9f6bdeced846";
    localparam string       V1_DIGITS    = "c232ab00941411ecb3c89f6bdeced846";

    typedef logic [7:0] t_text[$];

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    typedef struct {
        t_status     status;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [50:0] ms;
        logic [13:0] cseq;
        logic [47:0] node;
    } t_parsed_uuid;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic [7:0]         s_data = 8'h00;
    logic               s_last = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_data = 1'b0;
    logic               m_ready = 1'b0;
    logic               o_s_axis_tready;
    logic               o_cfg_ready;
    logic               o_m_axis_tvalid;
    logic [OUT_W-1:0]   o_m_axis_tdata;

    // Parser state as the block should hold it.
    logic               tolerant = 1'b0;
    logic [5:0]         text_pos = '0;
    logic [5:0]         nib_count = '0;
    logic [3:0]         nibbles[32];
    logic               dash_missing = 1'b0;
    logic               digit_bad = 1'b0;

    t_char_item         char_queue[$];
    t_parsed_uuid       expected_uuids[$];
    int                 chars_queued = 0;
    int                 chars_taken = 0;
    int                 mismatches = 0;
    int                 in_wait = 0;
    int                 in_calm = 0;
    int                 out_wait = 0;
    int                 out_calm = 0;
    int                 idle_cycles = 0;

    uuid_v1_text_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic decode_hex(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic void keep_nibble(input logic [3:0] v);
        if (nib_count < 32) begin
            nibbles[nib_count[4:0]] = v;
            nib_count++;
        end
    endfunction

    // Advances the parser by one character and queues the result on the last one.
    function automatic void absorb_char(input logic [7:0] c, input logic last);
        logic [3:0]   v;
        logic         ok;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [63:0]  ts;
        logic [63:0]  ticks;
        t_parsed_uuid r;
        ok = decode_hex(c, v);
        if (!tolerant) begin
            if (text_pos < 36) begin
                if (text_pos inside {6'd8, 6'd13, 6'd18, 6'd23}) begin
                    if (c != DASH_CHAR) dash_missing = 1'b1;
                end else begin
                    if (!ok) digit_bad = 1'b1;
                    keep_nibble(v);
                end
            end
        end else if (nib_count < 32 && c != DASH_CHAR) begin
            if (!ok) digit_bad = 1'b1;
            else if (!digit_bad) keep_nibble(v);
        end
        if (text_pos < 37) text_pos++;
        if (!last) return;

        hi = '0;
        lo = '0;
        for (int i = 0; i < 16; i++) hi = {hi[59:0], nibbles[i]};
        for (int i = 16; i < 32; i++) lo = {lo[59:0], nibbles[i]};
        if (!tolerant) begin
            if (text_pos != 36) r.status = ST_BAD_LEN;
            else if (dash_missing) r.status = ST_BAD_HYPHEN;
            else if (digit_bad) r.status = ST_BAD_HEX;
            else r.status = ST_OK;
        end else begin
            if (digit_bad) r.status = ST_BAD_HEX;
            else if (nib_count != 32) r.status = ST_BAD_LEN;
            else r.status = ST_OK;
        end
        if (r.status == ST_OK && hi[15:12] != 4'h1) r.status = ST_NOT_V1;

        r.hi = '0;
        r.lo = '0;
        r.ms = '0;
        r.cseq = '0;
        r.node = '0;
        if (r.status == ST_OK) begin
            // 60-bit timestamp: the 12 bits beside the version, then the middle
            // word, then the low word.
            ts = {4'h0, hi[11:0], hi[31:16], hi[63:32]};
            ticks = (ts - GREG_TO_UNIX) / 64'd10000;
            r.hi = hi;
            r.lo = lo;
            r.ms = ticks[50:0];
            r.cseq = lo[61:48];
            r.node = lo[47:0];
        end
        expected_uuids.push_back(r);
        text_pos = '0;
        nib_count = '0;
        dash_missing = 1'b0;
        digit_bad = 1'b0;
    endfunction

    // Per-item wait, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_char_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                absorb_char(s_data, s_last);
                chars_taken++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (in_wait > 0) begin
                    in_wait <= in_wait - 1;
                    s_valid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    nxt = char_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data <= nxt.ch;
                    s_last <= nxt.last;
                    in_wait <= draw_wait(in_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_parsed_uuid want;
        int w;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            out_wait <= 0;
        end else if (o_m_axis_tvalid && m_ready) begin
            if (expected_uuids.size() == 0) begin
                flag_mismatch("result with nothing expected",
                              64'(o_m_axis_tdata[2:0]), 64'd0);
            end else begin
                want = expected_uuids.pop_front();
                if (o_m_axis_tdata[2:0] !== want.status)
                    flag_mismatch("status", 64'(o_m_axis_tdata[2:0]), 64'(want.status));
                if (o_m_axis_tdata[66:3] !== want.hi)
                    flag_mismatch("uuid_high", o_m_axis_tdata[66:3], want.hi);
                if (o_m_axis_tdata[130:67] !== want.lo)
                    flag_mismatch("uuid_low", o_m_axis_tdata[130:67], want.lo);
                if (o_m_axis_tdata[181:131] !== want.ms)
                    flag_mismatch("time_ms", 64'(o_m_axis_tdata[181:131]), 64'(want.ms));
                if (o_m_axis_tdata[195:182] !== want.cseq)
                    flag_mismatch("clock_sequence", 64'(o_m_axis_tdata[195:182]),
                                  64'(want.cseq));
                if (o_m_axis_tdata[243:196] !== want.node)
                    flag_mismatch("node_id", 64'(o_m_axis_tdata[243:196]),
                                  64'(want.node));
            end
            w = draw_wait(out_calm);
            if (w > 0) begin
                m_ready <= 1'b0;
                out_wait <= w - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] mixed_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom);
            1: return DASH_CHAR;
            default: return hex_char(4'($urandom));
        endcase
    endfunction

    function automatic t_text from_str(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic t_text canonical_text(input logic [127:0] val);
        t_text t;
        for (int i = 0; i < 32; i++) begin
            if (i inside {8, 12, 16, 20}) t.push_back(DASH_CHAR);
            t.push_back(hex_char(val[127 - 4*i -: 4]));
        end
        return t;
    endfunction

    // Hyphens land anywhere; bytes after the 32nd digit are ignored by the block.
    function automatic t_text tolerant_text(input logic [127:0] val);
        t_text t;
        for (int i = 0; i < 32; i++) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) t.push_back(DASH_CHAR);
            t.push_back(hex_char(val[127 - 4*i -: 4]));
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) t.push_back(mixed_char());
        return t;
    endfunction

    function automatic t_text random_text(input logic tol);
        t_text t;
        logic [127:0] val;
        int n;
        val = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) != 0) val[79:76] = 4'h1;
        t = tol ? tolerant_text(val) : canonical_text(val);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: t[$urandom_range(0, t.size() - 1)] = mixed_char();
                1: t.delete($urandom_range(0, t.size() - 1));
                2: t.insert($urandom_range(0, t.size()), mixed_char());
                3: begin
                    n = $urandom_range(1, t.size() - 1);
                    while (t.size() > n) void'(t.pop_back());
                end
                4: repeat ($urandom_range(1, 8)) t.push_back(mixed_char());
                default: begin
                    t.delete();
                    repeat ($urandom_range(1, 45)) t.push_back(mixed_char());
                end
            endcase
        end
        return t;
    endfunction

    task automatic send_text(input t_text t);
        t_char_item it;
        foreach (t[i]) begin
            it.ch = t[i];
            it.last = (i == t.size() - 1);
            char_queue.push_back(it);
            chars_queued++;
        end
    endtask

    task automatic wait_until_idle();
        while (chars_taken != chars_queued || expected_uuids.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_parse_mode(input logic m);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        tolerant = m;
    endtask

    initial begin
        t_text t;
        int phase_chars;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Canonical form, reset mode.
        send_text(from_str("00000000-0000-1000-0000-000000000000"));
        send_text(from_str("FFFFFFFF-ffff-1FfF-fFfF-ffffffffffff"));
        send_text(from_str(V1_TEXT));
        send_text(from_str("c232ab00-9414-41ec-b3c8-9f6bdeced846"));
        t = from_str(V1_TEXT);
        void'(t.pop_back());
        send_text(t);
        send_text(from_str({V1_TEXT, "0"}));
        t = {8'hFF};
        send_text(t);
        send_text(from_str({V1_TEXT, "012345678"}));
        // A missing hyphen outranks a bad digit.
        t = from_str(V1_TEXT);
        t[8] = "0";
        send_text(t);
        t[20] = "g";
        send_text(t);
        t = from_str(V1_TEXT);
        t[0] = "g";
        send_text(t);
        t = from_str(V1_TEXT);
        t[35] = 8'h00;
        send_text(t);
        t = from_str(V1_TEXT);
        t[14] = 8'h80;
        send_text(t);
        t = from_str(V1_TEXT);
        t[1] = DASH_CHAR;
        send_text(t);
        wait_until_idle();

        write_parse_mode(1'b1);
        send_text(from_str(V1_DIGITS));
        send_text(from_str("-c232-ab00941411ec--b3c8-9f6bdeced846-"));
        t = from_str(V1_DIGITS);
        t.push_back("g");
        t.push_back(8'hFF);
        t.push_back("z");
        send_text(t);
        t = from_str(V1_DIGITS);
        void'(t.pop_back());
        send_text(t);
        t = from_str(V1_DIGITS);
        t[0] = "x";
        send_text(t);
        t = from_str(V1_DIGITS);
        t[31] = 8'h80;
        send_text(t);
        t = from_str(V1_DIGITS);
        t[12] = "2";
        send_text(t);
        send_text(from_str("-"));
        send_text(from_str("FFFFFFFFffff1fffFFFFffffffffffff"));
        send_text(from_str("00000000000010000000000000000000"));
        wait_until_idle();

        // Random strings; the mode alternates and is written only when idle.
        for (int ph = 0; ph < 6; ph++) begin
            write_parse_mode(1'(ph % 2));
            phase_chars = 0;
            while (phase_chars < 110) begin
                t = random_text(1'(ph % 2));
                phase_chars += t.size();
                send_text(t);
            end
            wait_until_idle();
        end

        if (mismatches == 0 && expected_uuids.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- uuid_v1_text_parser.f -----
design/uvtp_pkg.sv
design/uvtp_parser.sv
design/uvtp_prep.sv
design/uvtp_div_mul.sv
design/uvtp_div_rem.sv
design/uuid_v1_text_parser.sv
design/uvtp_checker.sv
tb/sv/tb_uuid_v1_text_parser.sv
